// ===== sv/assert_macros.svh =====
// assertion macros used by the channel hunt rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/rch_pkg.sv =====
// types, constants and helpers of the radio channel hunt block
package rch_pkg;

	localparam int unsigned CHAN_W        = 4;
	localparam int unsigned NUM_CHANNELS  = 13;
	localparam int unsigned NONCE_W       = 64;
	localparam int unsigned CMD_W         = 2;
	localparam int unsigned HB_W          = 10;
	localparam int unsigned MISS_W        = 4;
	localparam int unsigned CFG_IDX_W     = 2;
	localparam int unsigned CFG_DATA_W    = 13;

	localparam int unsigned DEF_FIRST_CHANNEL = 1;
	localparam int unsigned DEF_LAST_CHANNEL  = 13;

	localparam logic [CHAN_W-1:0] RESET_CHANNEL = 4'd1;

	// command codes
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REPLY = 2'd1;
	localparam logic [CMD_W-1:0] CMD_START = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HB_PERIOD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MISS_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOWED    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STORED     = 2'd3;

	localparam logic [HB_W-1:0]         RST_HB_PERIOD  = 10'd100;
	localparam logic [MISS_W-1:0]       RST_MISS_LIMIT = 4'd3;
	localparam logic [NUM_CHANNELS-1:0] RST_ALLOWED    = 13'h1FFF;
	localparam logic [CHAN_W-1:0]       RST_STORED     = 4'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HUNT,
		ST_PARK
	} hunt_state_t;

	typedef struct packed {
		logic [HB_W-1:0]         hb_period;
		logic [MISS_W-1:0]       miss_limit;
		logic [NUM_CHANNELS-1:0] allowed;
		logic [CHAN_W-1:0]       stored;
	} cfg_t;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [NONCE_W-1:0] nonce;
	} in_item_t;

	typedef struct packed {
		logic     valid;
		in_item_t item;
	} s1_t;

	typedef struct packed {
		logic               tune;
		logic [CHAN_W-1:0]  out_channel;
		logic               send_probe;
		logic [NONCE_W-1:0] probe_value;
		logic               save_request;
		logic [CHAN_W-1:0]  found_channel;
	} res_item_t;

	// channel n may be tuned when it lies in 1..13 and mask bit n-1 is set
	function automatic logic chan_ok(logic [CHAN_W-1:0] ch, logic [NUM_CHANNELS-1:0] mask);
		logic ok;
		if (ch < 4'd1 || ch > 4'(NUM_CHANNELS)) begin
			ok = 1'b0;
		end else begin
			ok = mask[4'(ch - 4'd1)];
		end
		return ok;
	endfunction

endpackage

// ===== sv/rch_ifs.sv =====
// handshake channel interfaces of the radio channel hunt block
interface rch_req_if import rch_pkg::*;;
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [NONCE_W-1:0] nonce;
	modport source (output valid, output cmd, output nonce, input ready);
	modport sink (input valid, input cmd, input nonce, output ready);
endinterface

interface rch_rsp_if import rch_pkg::*;;
	logic               valid;
	logic               ready;
	logic               tune;
	logic [CHAN_W-1:0]  out_channel;
	logic               send_probe;
	logic [NONCE_W-1:0] probe_value;
	logic               save_request;
	logic [CHAN_W-1:0]  found_channel;
	modport source (output valid, output tune, output out_channel, output send_probe,
		output probe_value, output save_request, output found_channel, input ready);
	modport sink (input valid, input tune, input out_channel, input send_probe,
		input probe_value, input save_request, input found_channel, output ready);
endinterface

interface rch_cfg_if import rch_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/rch_cfg_regs.sv =====
// configuration register file
module rch_cfg_regs import rch_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	rch_cfg_if.sink   cfg,
	output cfg_t      regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.hb_period  <= RST_HB_PERIOD;
			regs_q.miss_limit <= RST_MISS_LIMIT;
			regs_q.allowed    <= RST_ALLOWED;
			regs_q.stored     <= RST_STORED;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_HB_PERIOD:  regs_q.hb_period  <= cfg.data[HB_W-1:0];
				REG_MISS_LIMIT: regs_q.miss_limit <= cfg.data[MISS_W-1:0];
				REG_ALLOWED:    regs_q.allowed    <= cfg.data[NUM_CHANNELS-1:0];
				REG_STORED:     regs_q.stored     <= cfg.data[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== sv/rch_in_reg.sv =====
// input register stage
module rch_in_reg import rch_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	rch_req_if.sink req,
	input  logic    take,
	output s1_t     s1
);

	logic     valid_s1;
	in_item_t item_s1;

	// refill in the same cycle the held item moves on
	assign req.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.cmd   <= req.cmd;
			item_s1.nonce <= req.nonce;
		end
	end

	assign s1.valid = valid_s1;
	assign s1.item  = item_s1;

endmodule

// ===== sv/rch_hunt_core.sv =====
// hunt state, next-state logic and result register
module rch_hunt_core import rch_pkg::*; #(
	parameter int unsigned FIRST_CHANNEL = DEF_FIRST_CHANNEL,
	parameter int unsigned LAST_CHANNEL  = DEF_LAST_CHANNEL
) (
	input  logic      clk,
	input  logic      arst_n,
	input  s1_t       s1,
	input  cfg_t      regs,
	output logic      take,
	rch_rsp_if.source rsp
);

	localparam logic [CHAN_W-1:0] FIRST_CH = CHAN_W'(FIRST_CHANNEL);
	localparam logic [CHAN_W-1:0] LAST_CH  = CHAN_W'(LAST_CHANNEL);

	hunt_state_t        state_q, state_d;
	logic [CHAN_W-1:0]  cur_q, cur_d;
	logic [CHAN_W-1:0]  saved_q, saved_d;
	logic [HB_W-1:0]    tick_q, tick_d;
	logic [MISS_W-1:0]  miss_q, miss_d;
	logic [NONCE_W-1:0] last_q, last_d;
	logic               seen_q, seen_d;
	logic               rsp_valid_q;
	res_item_t          res_q, res_d;

	assign take = s1.valid && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_q   <= RESET_CHANNEL;
			saved_q <= RESET_CHANNEL;
			tick_q  <= '0;
			miss_q  <= '0;
			last_q  <= '0;
			seen_q  <= 1'b0;
		end else if (take) begin
			state_q <= state_d;
			cur_q   <= cur_d;
			saved_q <= saved_d;
			tick_q  <= tick_d;
			miss_q  <= miss_d;
			last_q  <= last_d;
			seen_q  <= seen_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_d;
		end
	end

	always_comb begin
		logic [CHAN_W-1:0] ch;
		logic [HB_W-1:0]   period;
		logic [HB_W-1:0]   tick_inc;
		logic [MISS_W-1:0] miss_inc;
		logic              tune;
		logic              probe;
		logic              save;

		state_d  = state_q;
		cur_d    = cur_q;
		saved_d  = saved_q;
		tick_d   = tick_q;
		miss_d   = miss_q;
		last_d   = last_q;
		seen_d   = seen_q;
		tune     = 1'b0;
		probe    = 1'b0;
		save     = 1'b0;
		ch       = regs.stored;
		period   = (regs.hb_period == '0) ? HB_W'(1) : regs.hb_period;
		tick_inc = tick_q + HB_W'(1);
		miss_inc = miss_q + MISS_W'(1);

		unique case (s1.item.cmd)
			CMD_START: begin
				if (ch < FIRST_CH || ch > LAST_CH) begin
					ch = FIRST_CH;
				end
				state_d = ST_HUNT;
				saved_d = ch;
				cur_d   = ch;
				tick_d  = '0;
				miss_d  = '0;
				seen_d  = 1'b0;
				if (chan_ok(ch, regs.allowed)) begin
					tune  = 1'b1;
					probe = 1'b1;
				end
			end
			CMD_REPLY: begin
				if (state_q != ST_IDLE && s1.item.nonce == last_q) begin
					seen_d = 1'b1;
				end
			end
			CMD_TICK: begin
				unique case (state_q)
					ST_HUNT: begin
						if (seen_q) begin
							state_d = ST_PARK;
							tick_d  = '0;
							miss_d  = '0;
							if (saved_q != cur_q) begin
								saved_d = cur_q;
								save    = 1'b1;
							end
						end else begin
							// round-robin step, forbidden channels sit silent
							cur_d = (cur_q >= LAST_CH) ? FIRST_CH : cur_q + CHAN_W'(1);
							if (chan_ok(cur_d, regs.allowed)) begin
								tune  = 1'b1;
								probe = 1'b1;
							end
						end
					end
					ST_PARK: begin
						if (tick_inc >= period) begin
							tick_d = '0;
							if (seen_q) begin
								miss_d = '0;
								probe  = 1'b1;
							end else begin
								miss_d = miss_inc;
								if (miss_inc >= regs.miss_limit) begin
									// too many silent heartbeats, hunt again
									state_d = ST_HUNT;
									cur_d   = saved_q;
									if (chan_ok(saved_q, regs.allowed)) begin
										tune  = 1'b1;
										probe = 1'b1;
									end
								end else begin
									probe = 1'b1;
								end
							end
						end else begin
							tick_d = tick_inc;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase

		if (probe) begin
			last_d = s1.item.nonce;
			seen_d = 1'b0;
		end

		res_d.tune          = tune;
		res_d.out_channel   = cur_d;
		res_d.send_probe    = probe;
		res_d.probe_value   = probe ? s1.item.nonce : '0;
		res_d.save_request  = save;
		res_d.found_channel = (state_d == ST_PARK) ? cur_d : '0;
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.tune          = res_q.tune;
	assign rsp.out_channel   = res_q.out_channel;
	assign rsp.send_probe    = res_q.send_probe;
	assign rsp.probe_value   = res_q.probe_value;
	assign rsp.save_request  = res_q.save_request;
	assign rsp.found_channel = res_q.found_channel;

endmodule

// ===== sv/radio_channel_hunt.sv =====
// an accepted item waits in the input register, then its result is registered when not stalled
// throughput: one item per cycle unless the result stalls; the hunt state updates once per item
// a stalled result holds in the result register while the input register takes one more item
// reset (arst_n low, asynchronous): hunt idle, channel 1, counters and nonce cleared
// configuration registers return to their defaults on reset
`include "assert_macros.svh"
module radio_channel_hunt import rch_pkg::*; #(
	parameter int unsigned FIRST_CHANNEL = DEF_FIRST_CHANNEL,
	parameter int unsigned LAST_CHANNEL  = DEF_LAST_CHANNEL
) (
	input  logic      clk,
	input  logic      arst_n,
	rch_req_if.sink   req,
	rch_rsp_if.source rsp,
	rch_cfg_if.sink   cfg
);

	cfg_t regs;
	s1_t  s1;
	logic take;

	rch_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	rch_in_reg u_in_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.take   (take),
		.s1     (s1)
	);

	rch_hunt_core #(
		.FIRST_CHANNEL (FIRST_CHANNEL),
		.LAST_CHANNEL  (LAST_CHANNEL)
	) u_hunt_core (
		.clk    (clk),
		.arst_n (arst_n),
		.s1     (s1),
		.regs   (regs),
		.take   (take),
		.rsp    (rsp)
	);

	`ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, req.valid && req.ready, s1.valid, "accepted item lost before input register")
	`ASSERT_IMPL(a_tune_probes, clk, arst_n, rsp.valid && rsp.tune, rsp.send_probe, "tune without probe")
	`ASSERT_IMPL(a_quiet_probe_zero, clk, arst_n, rsp.valid && !rsp.send_probe, rsp.probe_value == '0, "probe value without probe")
	`ASSERT_IMPL(a_save_when_parked, clk, arst_n, rsp.valid && rsp.save_request, rsp.found_channel == rsp.out_channel && rsp.found_channel != '0, "save request while not parked")

endmodule
